// ===== hdl/nlt_pkg.sv =====
`default_nettype none
package nlt_pkg;

	// table size default
	localparam int TABLE_DEPTH_DEF = 16;

	// field widths
	localparam int ACTION_W = 2;
	localparam int ID_W     = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int ENTRY_W  = 3 * ID_W;

	// request codes
	localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

	// result codes
	localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     node_id;
		logic [ID_W-1:0]     upstream_in;
		logic [ID_W-1:0]     downstream_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     upstream_out;
		logic [ID_W-1:0]     downstream_out;
		logic [COUNT_W-1:0]  entry_count;
	} rsp_t;

endpackage
`default_nettype wire

// ===== hdl/nlt_ram.sv =====
`default_nettype none
module nlt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/node_link_table_top.sv =====
// A request is accepted in idle, then walks the entry RAM one entry per cycle
// (search, skipped for an empty table), decides, and, for a remove, moves
// each later entry down one slot before the result is made ready.
// A new request is taken only once the current result has been placed in
// the output register, which waits while out_ready holds off a pending beat.
// Reset: arst_n clears the entry count and control; the RAM is not cleared.
`default_nettype none
module node_link_table_top #(
	parameter int TABLE_DEPTH = nlt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire nlt_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output nlt_pkg::rsp_t      out_data
);
	import nlt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SEARCH = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT  = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;

	logic [2:0]          state_q;
	req_t                req_q;
	logic                hit_q;
	logic [AW-1:0]       slot_q;
	logic [AW-1:0]       cmp_idx_q;
	logic [AW-1:0]       sh_idx_q;
	logic [CW-1:0]       count_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     up_q;
	logic [ID_W-1:0]     down_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                in_fire;
	logic                id_match;
	logic                last_cmp;
	logic                more_shift;
	logic                slot_has_next;
	logic                out_free;

	nlt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready      = (state_q == S_IDLE);
	assign in_fire       = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;
	assign out_free      = !out_valid_q || out_ready;
	assign id_match      = (ram_rdata[ENTRY_W-1 -: ID_W] == req_q.node_id);
	assign last_cmp      = ((CW + 1)'(cmp_idx_q) + 1'b1) == (CW + 1)'(count_q);
	assign slot_has_next = ((CW + 1)'(slot_q) + 1'b1) < (CW + 1)'(count_q);
	assign more_shift    = ((CW + 1)'(sh_idx_q) + 2'd2) < (CW + 1)'(count_q);

	// read address for the entry wanted next cycle
	always_comb begin
		unique case (state_q)
			S_SEARCH: ram_raddr = cmp_idx_q + 1'b1;
			S_DECIDE: ram_raddr = slot_q + 1'b1;
			S_SHIFT:  ram_raddr = sh_idx_q + AW'(2);
			default:  ram_raddr = '0;
		endcase
	end

	// write back: update, append, or move an entry down one slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = {req_q.node_id, req_q.upstream_in, req_q.downstream_in};
		unique case (state_q)
			S_DECIDE: begin
				if (req_q.action == ACT_ADD) begin
					if (hit_q) begin
						ram_we = 1'b1;
					end else if (count_q < DEPTH_C) begin
						ram_we    = 1'b1;
						ram_waddr = AW'(count_q);
					end
				end
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = sh_idx_q;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						hit_q     <= 1'b0;
						cmp_idx_q <= '0;
						state_q   <= (count_q == '0) ? S_DECIDE : S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (id_match) begin
						hit_q   <= 1'b1;
						slot_q  <= cmp_idx_q;
						up_q    <= ram_rdata[ENTRY_W-ID_W-1 -: ID_W];
						down_q  <= ram_rdata[ID_W-1:0];
						state_q <= S_DECIDE;
					end else if (last_cmp) begin
						state_q <= S_DECIDE;
					end else begin
						cmp_idx_q <= cmp_idx_q + 1'b1;
					end
				end
				S_DECIDE: begin
					status_q <= ST_MISSING;
					state_q  <= S_RESP;
					if (!(req_q.action == ACT_LOOKUP && hit_q)) begin
						up_q   <= '0;
						down_q <= '0;
					end
					case (req_q.action)
						ACT_ADD: begin
							if (hit_q) begin
								status_q <= ST_UPDATED;
							end else if (count_q >= DEPTH_C) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_ADDED;
								count_q  <= count_q + 1'b1;
							end
						end
						ACT_REMOVE: begin
							if (hit_q) begin
								status_q <= ST_DONE;
								if (slot_has_next) begin
									sh_idx_q <= slot_q;
									state_q  <= S_SHIFT;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
						end
						ACT_LOOKUP: begin
							if (hit_q) begin
								status_q <= ST_DONE;
							end
						end
						default: begin
							status_q <= ST_MISSING;
						end
					endcase
				end
				S_SHIFT: begin
					if (more_shift) begin
						sh_idx_q <= sh_idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the request, load the result beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q <= in_data;
		end
		if (state_q == S_RESP && out_free) begin
			out_q.status         <= status_q;
			out_q.upstream_out   <= up_q;
			out_q.downstream_out <= down_q;
			out_q.entry_count    <= COUNT_W'(count_q);
		end
	end

	// count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count beyond table depth");

	// search only walks valid entries
	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> (CW + 1)'(cmp_idx_q) < (CW + 1)'(count_q))
		else $error("search index past valid entries");

	// an append grows the table by exactly one
	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && req_q.action == ACT_ADD && !hit_q && count_q < DEPTH_C)
		|=> count_q == $past(count_q) + 1'b1)
		else $error("append did not grow the table");

	// a hit slot lies within the valid entries
	a_hit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE && hit_q) |-> (CW + 1)'(slot_q) < (CW + 1)'(count_q))
		else $error("hit slot outside valid entries");

endmodule
`default_nettype wire
